/* hdl/i4i8bsd_pkg.sv */
// Shared types, widths and sequencer states for the int4 x int8 block-scaled dot product.
// No dependencies; every other file of the block imports this package.
package i4i8bsd_pkg;

    // Number of lanes that one beat carries at most
    localparam int LANES_DEF = 8;

    // Field and datapath widths
    localparam int BYTE_W   = 8;
    localparam int WORD_W   = 64;
    localparam int SC_W     = 24;                  // unsigned Q8.16 scale
    localparam int FRAC_W   = 16;
    localparam int SCALE_W  = 2 * SC_W - FRAC_W;    // product cut to Q16.16
    localparam int PROD_W   = 12;                  // 4-bit weight times 8-bit activation
    localparam int GSUM_W   = 20;
    localparam int TERM_W   = GSUM_W + SCALE_W + 1;
    localparam int ACC_W    = 48;
    localparam int ASUM_W   = TERM_W + 1;
    localparam int IN_DATA_W  = 3 * WORD_W + 4 * SC_W;
    localparam int OUT_DATA_W = ACC_W;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_MERGE,
        S_GSUM,
        S_TERM,
        S_ACC_LO,
        S_ACC_HI,
        S_EMIT
    } dot_state_t;

    // Per-cycle enables that the sequencer hands to the datapath
    typedef struct packed {
        logic take;
        logic merge_en;
        logic gsum_en;
        logic term_en;
        logic acc_lo_en;
        logic acc_hi_en;
        logic emit_en;
    } dot_ctrl_t;

endpackage

/* hdl/int4_int8_block_scaled_dot_top.sv */
// Steps: lane products, merged part sums, group sums; a group end adds the scale multiply and
// two saturating adds, and an output end loads the output register in the emit step. The
// sequencer takes one beat at a time; for an output end it waits in its emit step while the
// output register is still full. The output register frees the input side while a result waits.
// Reset: rst_n asynchronous, active low; clears group sums, accumulator, clip flag,
// sequencer state and output valid.
// Top level of the int4 x int8 block-scaled dot product; uses i4i8bsd_pkg,
// i4i8bsd_lane and i4i8bsd_merge.
module int4_int8_block_scaled_dot_top #(
    parameter int LANES = i4i8bsd_pkg::LANES_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // weight_bytes, act_for_low, act_for_high, weight_scale_low, act_scale_low,
    // weight_scale_high, act_scale_high
    input  logic [i4i8bsd_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    input  logic                                  s_axis_tlast,   // last_in_output
    input  logic                                  s_axis_tuser,   // last_in_group
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [i4i8bsd_pkg::OUT_DATA_W-1:0]    m_axis_tdata,   // dot_product
    output logic                                  m_axis_tuser    // saturated
);
    import i4i8bsd_pkg::*;

    localparam int PART_W = PROD_W + $clog2(LANES);
    localparam int ACT_LO_OFS = WORD_W;
    localparam int ACT_HI_OFS = 2 * WORD_W;
    localparam int WS_LO_OFS  = 3 * WORD_W;
    localparam int AS_LO_OFS  = WS_LO_OFS + SC_W;
    localparam int WS_HI_OFS  = AS_LO_OFS + SC_W;
    localparam int AS_HI_OFS  = WS_HI_OFS + SC_W;

    dot_state_t state_reg, state_next;
    dot_ctrl_t  ctrl;
    logic       out_free;

    logic signed [PROD_W-1:0] prod_lo [LANES];
    logic signed [PROD_W-1:0] prod_hi [LANES];
    logic signed [PART_W-1:0] part_lo;
    logic signed [PART_W-1:0] part_hi;

    logic [SC_W-1:0]    ws_lo_reg, as_lo_reg, ws_hi_reg, as_hi_reg;
    logic               last_grp_reg, last_out_reg;
    logic [2*SC_W-1:0]  sprod_lo, sprod_hi;
    logic [SCALE_W-1:0] scale_lo_reg, scale_hi_reg;

    logic signed [GSUM_W-1:0] gsum_lo_reg, gsum_lo_next;
    logic signed [GSUM_W-1:0] gsum_hi_reg, gsum_hi_next;
    logic signed [GSUM_W:0]   gsum_lo_wide, gsum_hi_wide;
    logic                     gsum_lo_ovf, gsum_hi_ovf;

    logic signed [TERM_W-1:0] term_lo_reg, term_hi_reg;
    logic signed [TERM_W-1:0] term_sel;
    logic signed [ASUM_W-1:0] acc_wide;
    logic                     acc_ovf;
    logic signed [ACC_W-1:0]  acc_sat;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic                     clip_reg, clip_next;

    logic                  m_valid_reg, m_valid_next;
    logic [ACC_W-1:0]      m_data_reg;
    logic                  m_user_reg;

    // Lanes: one packed weight byte and its two activations each
    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        i4i8bsd_lane u_lane (
            .clk         (clk),
            .en          (ctrl.take),
            .weight_byte (s_axis_tdata[BYTE_W*g +: BYTE_W]),
            .act_lo      (s_axis_tdata[ACT_LO_OFS + BYTE_W*g +: BYTE_W]),
            .act_hi      (s_axis_tdata[ACT_HI_OFS + BYTE_W*g +: BYTE_W]),
            .prod_lo     (prod_lo[g]),
            .prod_hi     (prod_hi[g])
        );
    end

    i4i8bsd_merge #(.LANES(LANES)) u_merge (
        .clk     (clk),
        .en      (ctrl.merge_en),
        .prod_lo (prod_lo),
        .prod_hi (prod_hi),
        .part_lo (part_lo),
        .part_hi (part_hi)
    );

    assign out_free = !m_valid_reg || m_axis_tready;

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (s_axis_tvalid) state_next = S_MERGE;
            S_MERGE:  state_next = S_GSUM;
            S_GSUM:   state_next = last_grp_reg ? S_TERM : S_EMIT;
            S_TERM:   state_next = S_ACC_LO;
            S_ACC_LO: state_next = S_ACC_HI;
            S_ACC_HI: state_next = S_EMIT;
            S_EMIT:   if (!last_out_reg || out_free) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        ctrl          = '0;
        s_axis_tready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_axis_tready = 1'b1;
                ctrl.take     = s_axis_tvalid;
            end
            S_MERGE:  ctrl.merge_en  = 1'b1;
            S_GSUM:   ctrl.gsum_en   = 1'b1;
            S_TERM:   ctrl.term_en   = 1'b1;
            S_ACC_LO: ctrl.acc_lo_en = 1'b1;
            S_ACC_HI: ctrl.acc_hi_en = 1'b1;
            S_EMIT:   ctrl.emit_en   = last_out_reg && out_free;
            default:  ctrl = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Capture scales and markers of the accepted beat
    always_ff @(posedge clk)
    begin
        if (ctrl.take)
        begin
            ws_lo_reg    <= s_axis_tdata[WS_LO_OFS +: SC_W];
            as_lo_reg    <= s_axis_tdata[AS_LO_OFS +: SC_W];
            ws_hi_reg    <= s_axis_tdata[WS_HI_OFS +: SC_W];
            as_hi_reg    <= s_axis_tdata[AS_HI_OFS +: SC_W];
            last_grp_reg <= s_axis_tuser;
            last_out_reg <= s_axis_tlast;
        end
    end

    // Combine weight and activation scales, cut Q16.32 to Q16.16
    assign sprod_lo = (2*SC_W)'(ws_lo_reg) * (2*SC_W)'(as_lo_reg);
    assign sprod_hi = (2*SC_W)'(ws_hi_reg) * (2*SC_W)'(as_hi_reg);

    always_ff @(posedge clk)
    begin
        if (ctrl.merge_en)
        begin
            scale_lo_reg <= sprod_lo[2*SC_W-1 -: SCALE_W];
            scale_hi_reg <= sprod_hi[2*SC_W-1 -: SCALE_W];
        end
    end

    // Group-sum update; one extra bit exposes overflow
    assign gsum_lo_wide = (GSUM_W+1)'(gsum_lo_reg) + (GSUM_W+1)'(part_lo);
    assign gsum_hi_wide = (GSUM_W+1)'(gsum_hi_reg) + (GSUM_W+1)'(part_hi);
    assign gsum_lo_ovf  = gsum_lo_wide[GSUM_W] != gsum_lo_wide[GSUM_W-1];
    assign gsum_hi_ovf  = gsum_hi_wide[GSUM_W] != gsum_hi_wide[GSUM_W-1];

    // Scaled terms of the two groups
    always_ff @(posedge clk)
    begin
        if (ctrl.term_en)
        begin
            term_lo_reg <= TERM_W'(gsum_lo_reg) * TERM_W'($signed({1'b0, scale_lo_reg}));
            term_hi_reg <= TERM_W'(gsum_hi_reg) * TERM_W'($signed({1'b0, scale_hi_reg}));
        end
    end

    // Saturating accumulator add, low term first then high term
    assign term_sel = ctrl.acc_hi_en ? term_hi_reg : term_lo_reg;
    assign acc_wide = ASUM_W'(acc_reg) + ASUM_W'(term_sel);
    assign acc_ovf  = (acc_wide[ASUM_W-1:ACC_W-1] != '0)
                   && (acc_wide[ASUM_W-1:ACC_W-1] != '1);
    assign acc_sat  = acc_ovf ? (acc_wide[ASUM_W-1] ? {1'b1, {(ACC_W-1){1'b0}}}
                                                    : {1'b0, {(ACC_W-1){1'b1}}})
                              : acc_wide[ACC_W-1:0];

    // Next values of the running state
    always_comb
    begin
        gsum_lo_next = gsum_lo_reg;
        gsum_hi_next = gsum_hi_reg;
        acc_next     = acc_reg;
        clip_next    = clip_reg;
        if (ctrl.gsum_en)
        begin
            gsum_lo_next = gsum_lo_ovf
                ? (gsum_lo_wide[GSUM_W] ? {1'b1, {(GSUM_W-1){1'b0}}}
                                        : {1'b0, {(GSUM_W-1){1'b1}}})
                : gsum_lo_wide[GSUM_W-1:0];
            gsum_hi_next = gsum_hi_ovf
                ? (gsum_hi_wide[GSUM_W] ? {1'b1, {(GSUM_W-1){1'b0}}}
                                        : {1'b0, {(GSUM_W-1){1'b1}}})
                : gsum_hi_wide[GSUM_W-1:0];
            clip_next = clip_reg || gsum_lo_ovf || gsum_hi_ovf;
        end
        if (ctrl.acc_lo_en || ctrl.acc_hi_en)
        begin
            acc_next  = acc_sat;
            clip_next = clip_reg || acc_ovf;
        end
        // Terms are held in their registers, so drop the group sums now
        if (ctrl.acc_lo_en)
        begin
            gsum_lo_next = '0;
            gsum_hi_next = '0;
        end
        if (ctrl.emit_en)
        begin
            gsum_lo_next = '0;
            gsum_hi_next = '0;
            acc_next     = '0;
            clip_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gsum_lo_reg <= '0;
            gsum_hi_reg <= '0;
            acc_reg     <= '0;
            clip_reg    <= 1'b0;
        end
        else
        begin
            gsum_lo_reg <= gsum_lo_next;
            gsum_hi_reg <= gsum_hi_next;
            acc_reg     <= acc_next;
            clip_reg    <= clip_next;
        end
    end

    // Output register: load on emit, release when the beat is taken
    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
        if (ctrl.emit_en)
        begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.emit_en)
        begin
            m_data_reg <= acc_reg;
            m_user_reg <= clip_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

`ifndef SYNTH
    // A result clears the running state for the next dot product
    a_clear_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.emit_en |=> (acc_reg == '0) && !clip_reg && (gsum_lo_reg == '0)
                         && (gsum_hi_reg == '0))
        else $error("running state not cleared after result");

    // Group sums are dropped once the low term has been added
    a_gsum_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ACC_LO) |=> (gsum_lo_reg == '0) && (gsum_hi_reg == '0))
        else $error("group sums kept after scaling");

    // Scaling runs only for a beat that ends a group
    a_term_on_group: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TERM) |-> ($past(state_reg) == S_GSUM) && last_grp_reg)
        else $error("scaling entered without group end");

    // A new result appears only from the emit step
    a_valid_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> ($past(state_reg) == S_EMIT) && $past(last_out_reg))
        else $error("output valid raised outside emit");
`endif

endmodule

/* hdl/i4i8bsd_lane.sv */
// One lane: signed products of a packed weight byte's two nibbles with their activations.
// Depends on i4i8bsd_pkg for the product width.
module i4i8bsd_lane (
    input  logic                                  clk,
    input  logic                                  en,
    input  logic [i4i8bsd_pkg::BYTE_W-1:0]        weight_byte,
    input  logic [i4i8bsd_pkg::BYTE_W-1:0]        act_lo,
    input  logic [i4i8bsd_pkg::BYTE_W-1:0]        act_hi,
    output logic signed [i4i8bsd_pkg::PROD_W-1:0] prod_lo,
    output logic signed [i4i8bsd_pkg::PROD_W-1:0] prod_hi
);
    import i4i8bsd_pkg::*;

    logic signed [3:0]        w_lo;
    logic signed [3:0]        w_hi;
    logic signed [PROD_W-1:0] prod_lo_reg;
    logic signed [PROD_W-1:0] prod_hi_reg;

    // Remove the offset of 8: flipping the nibble's top bit gives nibble - 8
    assign w_lo = {~weight_byte[3], weight_byte[2:0]};
    assign w_hi = {~weight_byte[7], weight_byte[6:4]};

    // Capture both products on the accepted beat
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_lo_reg <= PROD_W'(w_lo) * PROD_W'($signed(act_lo));
            prod_hi_reg <= PROD_W'(w_hi) * PROD_W'($signed(act_hi));
        end
    end

    assign prod_lo = prod_lo_reg;
    assign prod_hi = prod_hi_reg;

endmodule

/* hdl/i4i8bsd_merge.sv */
// Merge stage: adds the lane products into one low-nibble and one high-nibble part sum.
// Depends on i4i8bsd_pkg; fed by the i4i8bsd_lane instances.
module i4i8bsd_merge #(
    parameter  int LANES  = i4i8bsd_pkg::LANES_DEF,
    localparam int PART_W = i4i8bsd_pkg::PROD_W + $clog2(LANES)
) (
    input  logic                                  clk,
    input  logic                                  en,
    input  logic signed [i4i8bsd_pkg::PROD_W-1:0] prod_lo [LANES],
    input  logic signed [i4i8bsd_pkg::PROD_W-1:0] prod_hi [LANES],
    output logic signed [PART_W-1:0]              part_lo,
    output logic signed [PART_W-1:0]              part_hi
);
    import i4i8bsd_pkg::*;

    logic signed [PART_W-1:0] sum_lo;
    logic signed [PART_W-1:0] sum_hi;
    logic signed [PART_W-1:0] part_lo_reg;
    logic signed [PART_W-1:0] part_hi_reg;

    // Add the lanes, sign-extended to the part width
    always_comb
    begin
        sum_lo = '0;
        sum_hi = '0;
        for (int i = 0; i < LANES; i++)
        begin
            sum_lo = sum_lo + PART_W'(prod_lo[i]);
            sum_hi = sum_hi + PART_W'(prod_hi[i]);
        end
    end

    // Hold the merged sums for the group-sum update
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            part_lo_reg <= sum_lo;
            part_hi_reg <= sum_hi;
        end
    end

    assign part_lo = part_lo_reg;
    assign part_hi = part_hi_reg;

endmodule

/* bench/tb_int4_int8_block_scaled_dot_top.sv */
// Self-checking bench for int4_int8_block_scaled_dot_top: a directed table, then random
// quantization groups and dot products under bursty input and a stalling output.
// Depends on i4i8bsd_pkg and the top module under hdl/.
module tb_int4_int8_block_scaled_dot_top;

    timeunit 1ns;
    timeprecision 1ps;

    import i4i8bsd_pkg::*;

    localparam int LANES = LANES_DEF;
    localparam int RANDOM_BEATS = 1065;
    localparam int LONG_HOLD = 300;
    localparam int HOLD_START = 400;
    localparam int DRAIN_CYCLES = 20;
    localparam int SAT_REPS = 70;
    localparam int RESET_CYCLES = 10;
    localparam int MAX_REPORTS = 10;
    localparam int LIMIT_NS = 2_000_000;
    localparam int NIBBLE_OFS = 8;
    localparam int BYTES_PER_WORD = WORD_W / BYTE_W;
    localparam realtime HALF_PERIOD = 2ns;

    localparam longint GSUM_HI = (longint'(1) <<< (GSUM_W - 1)) - 1;
    localparam longint GSUM_LO = -(longint'(1) <<< (GSUM_W - 1));
    localparam longint ACC_HI = (longint'(1) <<< (ACC_W - 1)) - 1;
    localparam longint ACC_LO = -(longint'(1) <<< (ACC_W - 1));

    localparam logic [SC_W-1:0] Q_ZERO = 24'h000000;
    localparam logic [SC_W-1:0] Q_ONE = 24'h010000;
    localparam logic [SC_W-1:0] Q_MAX = 24'hFFFFFF;
    localparam logic [WORD_W-1:0] ACT_NEG = {8{8'h80}};
    localparam logic [WORD_W-1:0] ACT_POS = {8{8'h7F}};
    localparam logic [WORD_W-1:0] ACT_ONE = {8{8'h01}};
    localparam logic [WORD_W-1:0] W_ZERO = {8{8'h88}};    // every weight 0
    localparam logic [WORD_W-1:0] W_ONE = {8{8'h99}};     // every weight +1
    localparam logic [WORD_W-1:0] W_NEG8 = {8{8'h00}};    // every weight -8

    typedef struct {
        logic [WORD_W-1:0] weight_bytes;
        logic [WORD_W-1:0] act_for_low;
        logic [WORD_W-1:0] act_for_high;
        logic [SC_W-1:0]   ws_low;
        logic [SC_W-1:0]   as_low;
        logic [SC_W-1:0]   ws_high;
        logic [SC_W-1:0]   as_high;
        logic              last_in_group;
        logic              last_in_output;
    } dot_beat_t;

    typedef struct packed {
        logic [ACC_W-1:0] dot;
        logic             sat;
    } dot_res_t;

    typedef struct {
        dot_beat_t beat;
        int        reps;
        bit        typed;
        dot_res_t  want;
    } plan_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata = '0;
    logic                   s_axis_tlast = 1'b0;
    logic                   s_axis_tuser = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;
    logic                   m_axis_tuser;
    logic                   hold_req = 1'b0;

    // Predicted dot products, oldest first
    dot_res_t expected_dots[$];

    // Running state of the predictor
    longint model_low = 0;
    longint model_high = 0;
    longint model_acc = 0;
    bit     model_clip = 1'b0;

    int  burst_left = 0;
    int  beats_sent = 0;
    int  mismatches = 0;

    plan_row_t directed_rows[$];

    int4_int8_block_scaled_dot_top #(.LANES(LANES)) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Clock
    always #(HALF_PERIOD) clk = ~clk;

    // Saturate to [lo, hi]; a clip marks the running dot product
    function automatic longint model_sat(input longint v, input longint lo, input longint hi);
        if (v > hi)
        begin
            model_clip = 1'b1;
            return hi;
        end
        if (v < lo)
        begin
            model_clip = 1'b1;
            return lo;
        end
        return v;
    endfunction

    // Scale one group sum by the Q16.16 product of its scales and add it
    function automatic void model_add_scaled(input longint sum, input logic [SC_W-1:0] ws,
                                             input logic [SC_W-1:0] asc);
        longint scale;
        scale = (longint'(ws) * longint'(asc)) >>> FRAC_W;
        model_acc = model_sat(model_acc + sum * scale, ACC_LO, ACC_HI);
    endfunction

    // Advance the predictor by one accepted beat; return 1 when it gives a result
    function automatic bit model_step(input dot_beat_t b, output dot_res_t res);
        longint     lo_part;
        longint     hi_part;
        logic [7:0] wb;
        lo_part = 0;
        hi_part = 0;
        res = '0;
        for (int i = 0; i < LANES && i < BYTES_PER_WORD; i++)
        begin
            wb = b.weight_bytes[BYTE_W*i +: BYTE_W];
            lo_part += (longint'(wb[3:0]) - NIBBLE_OFS)
                       * longint'($signed(b.act_for_low[BYTE_W*i +: BYTE_W]));
            hi_part += (longint'(wb[7:4]) - NIBBLE_OFS)
                       * longint'($signed(b.act_for_high[BYTE_W*i +: BYTE_W]));
        end
        model_low = model_sat(model_low + lo_part, GSUM_LO, GSUM_HI);
        model_high = model_sat(model_high + hi_part, GSUM_LO, GSUM_HI);
        if (b.last_in_group)
        begin
            model_add_scaled(model_low, b.ws_low, b.as_low);
            model_add_scaled(model_high, b.ws_high, b.as_high);
            model_low = 0;
            model_high = 0;
        end
        if (b.last_in_output)
        begin
            res.dot = ACC_W'(model_acc);
            res.sat = model_clip;
            model_low = 0;
            model_high = 0;
            model_acc = 0;
            model_clip = 1'b0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Pack one beat onto tdata, first field in the lowest bits
    function automatic logic [IN_DATA_W-1:0] pack_beat(input dot_beat_t b);
        return {b.as_high, b.ws_high, b.as_low, b.ws_low,
                b.act_for_high, b.act_for_low, b.weight_bytes};
    endfunction

    // One table row: the same scale pair on both nibble groups
    function automatic plan_row_t make_row(input logic [WORD_W-1:0] w,
                                           input logic [WORD_W-1:0] act_lo,
                                           input logic [WORD_W-1:0] act_hi,
                                           input logic [SC_W-1:0]   ws,
                                           input logic [SC_W-1:0]   asc,
                                           input logic              grp_end,
                                           input logic              out_end,
                                           input int                reps,
                                           input bit                typed,
                                           input logic [ACC_W-1:0]  dot,
                                           input logic              sat);
        plan_row_t row;
        row.beat.weight_bytes   = w;
        row.beat.act_for_low    = act_lo;
        row.beat.act_for_high   = act_hi;
        row.beat.ws_low         = ws;
        row.beat.as_low         = asc;
        row.beat.ws_high        = ws;
        row.beat.as_high        = asc;
        row.beat.last_in_group  = grp_end;
        row.beat.last_in_output = out_end;
        row.reps                = reps;
        row.typed               = typed;
        row.want.dot            = dot;
        row.want.sat            = sat;
        return row;
    endfunction

    // Directed table; typed results only where they follow directly from the inputs
    function automatic void build_directed();
        // Zero weights right after reset
        directed_rows.push_back(make_row(W_ZERO, ACT_POS, ACT_NEG, Q_ONE, Q_ONE,
                                         1'b1, 1'b1, 1, 1'b1, '0, 1'b0));
        // Zero scales wipe out any sum
        directed_rows.push_back(make_row(W_NEG8, ACT_POS, ACT_POS, Q_ZERO, Q_ZERO,
                                         1'b1, 1'b1, 1, 1'b1, '0, 1'b0));
        // Eight unit products per group at unit scale: 16.0
        directed_rows.push_back(make_row(W_ONE, ACT_ONE, ACT_ONE, Q_ONE, Q_ONE,
                                         1'b1, 1'b1, 1, 1'b1, 48'h0000_0010_0000, 1'b0));
        // End of output without end of group drops the unscaled sums
        directed_rows.push_back(make_row(W_ONE, ACT_ONE, ACT_ONE, Q_ONE, Q_ONE,
                                         1'b0, 1'b1, 1, 1'b1, '0, 1'b0));
        // Group sums clip high, unit scales
        directed_rows.push_back(make_row(W_NEG8, ACT_NEG, ACT_NEG, Q_ONE, Q_ONE,
                                         1'b0, 1'b0, SAT_REPS, 1'b0, '0, 1'b0));
        directed_rows.push_back(make_row(W_NEG8, ACT_NEG, ACT_NEG, Q_ONE, Q_ONE,
                                         1'b1, 1'b1, 1, 1'b1, 48'h000F_FFFE_0000, 1'b1));
        // Accumulator clips high
        directed_rows.push_back(make_row(W_NEG8, ACT_NEG, ACT_NEG, Q_MAX, Q_MAX,
                                         1'b0, 1'b0, SAT_REPS, 1'b0, '0, 1'b0));
        directed_rows.push_back(make_row(W_NEG8, ACT_NEG, ACT_NEG, Q_MAX, Q_MAX,
                                         1'b1, 1'b1, 1, 1'b1, 48'h7FFF_FFFF_FFFF, 1'b1));
        // Accumulator clips low
        directed_rows.push_back(make_row(W_NEG8, ACT_POS, ACT_POS, Q_MAX, Q_MAX,
                                         1'b0, 1'b0, SAT_REPS, 1'b0, '0, 1'b0));
        directed_rows.push_back(make_row(W_NEG8, ACT_POS, ACT_POS, Q_MAX, Q_MAX,
                                         1'b1, 1'b1, 1, 1'b1, 48'h8000_0000_0000, 1'b1));
        // Clip flag is cleared by the previous result
        directed_rows.push_back(make_row(W_ZERO, ACT_NEG, ACT_POS, Q_ONE, Q_ONE,
                                         1'b1, 1'b1, 1, 1'b1, '0, 1'b0));
        // Several groups in one dot product
        directed_rows.push_back(make_row(64'h0123_4567_89AB_CDEF, 64'h80FF_7F01_10F0_55AA,
                                         64'h7F80_0102_FEFD_3344, 24'h018000, 24'h00C000,
                                         1'b1, 1'b0, 3, 1'b0, '0, 1'b0));
        directed_rows.push_back(make_row(64'hF0E1_D2C3_B4A5_9687, 64'h0102_0304_F0F1_F2F3,
                                         64'h8081_7F7E_0000_FFFF, 24'h00C000, 24'h123456,
                                         1'b0, 1'b0, 5, 1'b0, '0, 1'b0));
        directed_rows.push_back(make_row(64'hFEDC_BA98_7654_3210, 64'h55AA_33CC_0FF0_8001,
                                         64'h1234_5678_9ABC_DEF0, Q_MAX, 24'h000100,
                                         1'b1, 1'b1, 1, 1'b0, '0, 1'b0));
        // Results back to back
        directed_rows.push_back(make_row(W_ONE, ACT_ONE, ACT_NEG, Q_ONE, Q_ONE,
                                         1'b1, 1'b1, 8, 1'b0, '0, 1'b0));
    endfunction

    // Random scale, biased toward zero, one and full scale
    function automatic logic [SC_W-1:0] random_scale();
        int pick;
        pick = $urandom_range(0, 7);
        unique case (pick)
            0:       return Q_ZERO;
            1:       return Q_ONE;
            2:       return Q_MAX;
            default: return SC_W'($urandom);
        endcase
    endfunction

    // Random beat; the closing beat ends both its group and the dot product
    function automatic dot_beat_t random_beat(input bit closing);
        dot_beat_t b;
        int        mode;
        mode = $urandom_range(0, 9);
        b.weight_bytes = {$urandom, $urandom};
        b.act_for_low  = {$urandom, $urandom};
        b.act_for_high = {$urandom, $urandom};
        if (mode == 0)
        begin
            b.weight_bytes = W_NEG8;
            b.act_for_low  = ACT_NEG;
            b.act_for_high = ACT_POS;
        end
        if (mode == 1)
        begin
            b.weight_bytes = W_NEG8;
            b.act_for_low  = ACT_POS;
            b.act_for_high = ACT_NEG;
        end
        b.ws_low         = random_scale();
        b.as_low         = random_scale();
        b.ws_high        = random_scale();
        b.as_high        = random_scale();
        b.last_in_group  = ($urandom_range(0, 3) == 0);
        b.last_in_output = ($urandom_range(0, 11) == 0);
        if (closing)
        begin
            b.last_in_group  = 1'b1;
            b.last_in_output = 1'b1;
        end
        return b;
    endfunction

    // Offer one beat, hold it until accepted, then predict its result
    task automatic send_beat(input dot_beat_t b, input bit typed, input dot_res_t want);
        dot_res_t got;
        bit       has_res;
        int       gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pack_beat(b);
        s_axis_tlast  <= b.last_in_output;
        s_axis_tuser  <= b.last_in_group;
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        has_res = model_step(b, got);
        if (has_res)
        begin
            expected_dots.push_back(typed ? want : got);
        end
        beats_sent++;
        burst_left--;
    endtask

    // Stimulus: reset, directed table, random beats, then drain
    initial
    begin : stimulus
        plan_row_t row;
        dot_beat_t beat;
        build_directed();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed_rows[r])
        begin
            row = directed_rows[r];
            repeat (row.reps) send_beat(row.beat, row.typed, row.want);
        end
        for (int n = 0; n < RANDOM_BEATS; n++)
        begin
            beat = random_beat(n == RANDOM_BEATS - 1);
            send_beat(beat, 1'b0, '0);
        end
        s_axis_tvalid <= 1'b0;
        while (expected_dots.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Long receiver hold while the sender keeps offering beats
    initial
    begin : long_hold
        int held;
        held = 0;
        wait (beats_sent >= HOLD_START);
        @(posedge clk);
        hold_req <= 1'b1;
        while (held < LONG_HOLD)
        begin
            @(posedge clk);
            held++;
        end
        hold_req <= 1'b0;
    end

    // Receiver: random stalls, held low during the long hold
    always @(posedge clk)
    begin
        if (!rst_n || hold_req)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(0, 99) >= 30);
    end

    // Check every output beat against the oldest prediction
    always @(posedge clk)
    begin : out_mon
        dot_res_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_dots.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("mismatch: expected no result, actual dot=%h sat=%b",
                             m_axis_tdata, m_axis_tuser);
            end
            else
            begin
                want = expected_dots.pop_front();
                if (m_axis_tdata !== want.dot || m_axis_tuser !== want.sat)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("mismatch: expected dot=%h sat=%b, actual dot=%h sat=%b",
                                 want.dot, want.sat, m_axis_tdata, m_axis_tuser);
                end
            end
        end
    end

    // Run limit
    initial
    begin : watchdog
        #(LIMIT_NS * 1ns);
        $display("FAIL");
        $finish;
    end

endmodule
